// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define TISF_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("tisf assertion failed");

// Checked at every edge, reset included.
`define TISF_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("tisf assertion failed");

`endif

// ----- rtl/tisf_pkg.sv -----
// Shared types and byte codes of the telnet IAC stream filter.
// No dependencies.
package tisf_pkg;

	localparam logic [7:0] CODE_IAC    = 8'd255;
	localparam logic [7:0] CODE_DONT   = 8'd254;
	localparam logic [7:0] CODE_DO     = 8'd253;
	localparam logic [7:0] CODE_WONT   = 8'd252;
	localparam logic [7:0] CODE_WILL   = 8'd251;
	localparam logic [7:0] CODE_BREAK  = 8'd243;
	localparam logic [7:0] CHAR_BSLASH = 8'h5C;
	localparam logic [7:0] CHAR_LOW_B  = 8'h62;

	localparam logic OP_RX = 1'b0;
	localparam logic OP_TX = 1'b1;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// One queued emit command: one byte, or a pair when pair is set.
	typedef struct packed {
		logic       pair;
		logic [7:0] b0;
		logic [7:0] b1;
	} cmd_t;

endpackage

// ----- rtl/tisf_ifs.sv -----
// Valid/ready channel interfaces: input items, result items, config writes.
// Depends on tisf_pkg.
interface tisf_item_if;
	logic       valid;
	logic       ready;
	logic       operation;
	logic [7:0] in_byte;
	modport source (output valid, output operation, output in_byte, input ready);
	modport sink (input valid, input operation, input in_byte, output ready);
endinterface

interface tisf_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_of_run;
	modport source (output valid, output out_byte, output last_of_run, input ready);
	modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

interface tisf_cfg_if;
	logic valid;
	logic ready;
	logic data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/telnet_iac_stream_filter.sv -----
// Channel   Dir  Payload                    Handshake
// item      in   operation, in_byte         valid/ready
// result    out  out_byte, last_of_run      valid/ready
// cfg       in   data (transparent_mode)    valid/ready, ready always high
//
// One item is accepted per cycle while the two-entry command queue has room.
// Each item gives zero, one or two result items; the back end sends one
// result per cycle while result.ready is high. An accepted item is
// registered in the command queue and then in the output register.
// Reset (arst_n low) clears parser state, escape flag, queue and output
// valid. A stalled result side fills the queue and then drops item.ready.
// Depends on tisf_pkg, tisf_ifs, tisf_front, tisf_queue, tisf_back.
module telnet_iac_stream_filter (
	input  logic           clk,
	input  logic           arst_n,
	tisf_item_if.sink      item,
	tisf_result_if.source  result,
	tisf_cfg_if.sink       cfg
);
	import tisf_pkg::*;

	logic transparent_q;
	logic push, q_full, pop, head_valid;
	cmd_t push_cmd, head_cmd;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			transparent_q <= 1'b0;
		end else if (cfg.valid) begin
			transparent_q <= cfg.data;
		end
	end

	tisf_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.transparent (transparent_q),
		.q_full      (q_full),
		.push        (push),
		.push_cmd    (push_cmd)
	);

	tisf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	tisf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.result     (result)
	);

endmodule

// ----- rtl/tisf_front.sv -----
// Front end: accepts items, runs the receive parser and transmit escape
// logic, and pushes emit commands. Depends on tisf_pkg, tisf_ifs.
module tisf_front (
	input  logic            clk,
	input  logic            arst_n,
	tisf_item_if.sink       item,
	input  logic            transparent,
	input  logic            q_full,
	output logic            push,
	output tisf_pkg::cmd_t  push_cmd
);
	import tisf_pkg::*;

	localparam logic [1:0] RX_DATA    = 2'd0;
	localparam logic [1:0] RX_COMMAND = 2'd1;
	localparam logic [1:0] RX_OPTION  = 2'd2;

	logic [1:0] rx_state_q, rx_state_d;
	logic       esc_q, esc_d;
	logic       emit;
	logic       accept;
	logic [7:0] b;

	assign item.ready = !q_full;
	assign accept = item.valid && item.ready;
	assign b = item.in_byte;

	always_comb begin
		rx_state_d = rx_state_q;
		esc_d = esc_q;
		emit = 1'b0;
		push_cmd.pair = 1'b0;
		push_cmd.b0 = b;
		push_cmd.b1 = CODE_IAC;
		if (item.operation == OP_RX) begin
			unique case (rx_state_q)
				RX_COMMAND: begin
					if (b == CODE_IAC) begin
						emit = 1'b1;
						rx_state_d = RX_DATA;
					end else if (b == CODE_DO || b == CODE_DONT ||
							b == CODE_WILL || b == CODE_WONT) begin
						rx_state_d = RX_OPTION;
					end else begin
						rx_state_d = RX_DATA;
					end
				end
				RX_OPTION: begin
					rx_state_d = RX_DATA;
				end
				default: begin
					if (b == CODE_IAC) begin
						rx_state_d = RX_COMMAND;
					end else begin
						rx_state_d = RX_DATA;
						emit = 1'b1;
					end
				end
			endcase
		end else begin
			if (!transparent && !esc_q && b == CHAR_BSLASH) begin
				esc_d = 1'b1;
			end else if (!transparent && esc_q && b == CHAR_LOW_B) begin
				esc_d = 1'b0;
				emit = 1'b1;
				push_cmd.pair = 1'b1;
				push_cmd.b0 = CODE_IAC;
				push_cmd.b1 = CODE_BREAK;
			end else begin
				if (!transparent) begin
					esc_d = 1'b0;
				end
				emit = 1'b1;
				push_cmd.pair = (b == CODE_IAC);
			end
		end
	end

	assign push = accept && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_state_q <= RX_DATA;
			esc_q <= 1'b0;
		end else if (accept) begin
			rx_state_q <= rx_state_d;
			esc_q <= esc_d;
		end
	end

endmodule

// ----- rtl/tisf_queue.sv -----
// Short command queue between front and back ends.
// Depends on tisf_pkg.
module tisf_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  tisf_pkg::cmd_t  push_cmd,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output tisf_pkg::cmd_t  head_cmd
);
	import tisf_pkg::*;

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_pop;

	assign full = (count_q == QCNT_W'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd = mem_q[rd_ptr_q];
	assign do_pop = pop && head_valid;

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		next_ptr = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/tisf_back.sv -----
// Back end: turns queued commands into one or two result items.
// Depends on tisf_pkg, tisf_ifs.
module tisf_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  tisf_pkg::cmd_t  head_cmd,
	output logic            pop,
	tisf_result_if.source   result
);
	import tisf_pkg::*;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;
	logic       hold_q;
	logic [7:0] second_q;
	logic       taken;

	assign result.valid = out_valid_q;
	assign result.out_byte = out_byte_q;
	assign result.last_of_run = out_last_q;
	assign taken = out_valid_q && result.ready;
	assign pop = head_valid && (!out_valid_q || (taken && !hold_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			hold_q <= 1'b0;
		end else if (taken && hold_q) begin
			hold_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
			hold_q <= head_cmd.pair;
		end else if (taken) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (taken && hold_q) begin
			out_byte_q <= second_q;
			out_last_q <= 1'b1;
		end else if (pop) begin
			out_byte_q <= head_cmd.b0;
			out_last_q <= !head_cmd.pair;
			second_q <= head_cmd.b1;
		end
	end

endmodule

// ----- rtl/tisf_checker.sv -----
// Port-level checks on the filter's result channel, bound to the top level.
// Depends on tisf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tisf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       out_last
);
	import tisf_pkg::*;

	logic pair_tail_ok;

	assign pair_tail_ok = out_valid && out_last &&
		(out_byte == CODE_IAC || out_byte == CODE_BREAK);

	`TISF_ASSERT_ALWAYS(a_reset_idle, clk, !arst_n |-> !out_valid)
	`TISF_ASSERT(a_valid_holds, clk, arst_n, out_valid && !out_ready |=> out_valid)
	`TISF_ASSERT(a_first_is_iac, clk, arst_n, out_valid && !out_last |-> out_byte == CODE_IAC)
	`TISF_ASSERT(a_pair_follows, clk, arst_n, out_valid && out_ready && !out_last |=> pair_tail_ok)

endmodule

bind telnet_iac_stream_filter tisf_checker u_tisf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_byte  (result.out_byte),
	.out_last  (result.last_of_run)
);
